// ----- rtl/ocx_pkg.sv -----
// ocx_pkg: shared types, codes and the microcode table of the order crossover engine
// depends on nothing; imported by order_crossover_permutation

package ocx_pkg;

   // request modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // result kinds
   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_GENE = 1'b1;

   // microprogram counter
   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   // microprogram step addresses
   localparam upc_type STEP_IDLE      = 4'd0;
   localparam upc_type STEP_READ_OUT  = 4'd1;
   localparam upc_type STEP_RED_S     = 4'd2;
   localparam upc_type STEP_RED_E     = 4'd3;
   localparam upc_type STEP_CLR_INIT  = 4'd4;
   localparam upc_type STEP_CLR       = 4'd5;
   localparam upc_type STEP_KEEP_INIT = 4'd6;
   localparam upc_type STEP_KEEP      = 4'd7;
   localparam upc_type STEP_WALK_INIT = 4'd8;
   localparam upc_type STEP_WALK      = 4'd9;
   localparam upc_type STEP_ACK       = 4'd10;

   // datapath action of one step
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_IDLE,
      ACT_EMIT_READ,
      ACT_RED_S,
      ACT_RED_E,
      ACT_CLR_INIT,
      ACT_CLR,
      ACT_KEEP_INIT,
      ACT_KEEP,
      ACT_WALK_INIT,
      ACT_WALK,
      ACT_EMIT_ACK
   } act_type;

   // how the step counter moves
   typedef enum logic [1:0] {
      BR_NEXT,
      BR_GOTO,
      BR_WAIT,
      BR_DISPATCH
   } br_type;

   // branch conditions
   typedef enum logic [2:0] {
      COND_NONE,
      COND_OUT_FREE,
      COND_S_LT_N,
      COND_E_LT_N,
      COND_CLR_LAST,
      COND_KEEP_DONE,
      COND_WALK_DONE
   } cond_type;

   typedef struct packed {
      act_type  act;
      br_type   br;
      cond_type cond;
      upc_type  target;
   } ctrl_word_type;

   // control store
   function automatic ctrl_word_type ucode_word(input upc_type step);
      ctrl_word_type w;
      case (step)
         STEP_IDLE:      w = '{ACT_IDLE,      BR_DISPATCH, COND_NONE,      STEP_RED_S};
         STEP_READ_OUT:  w = '{ACT_EMIT_READ, BR_WAIT,     COND_OUT_FREE,  STEP_IDLE};
         STEP_RED_S:     w = '{ACT_RED_S,     BR_WAIT,     COND_S_LT_N,    STEP_RED_E};
         STEP_RED_E:     w = '{ACT_RED_E,     BR_WAIT,     COND_E_LT_N,    STEP_CLR_INIT};
         STEP_CLR_INIT:  w = '{ACT_CLR_INIT,  BR_NEXT,     COND_NONE,      STEP_IDLE};
         STEP_CLR:       w = '{ACT_CLR,       BR_WAIT,     COND_CLR_LAST,  STEP_KEEP_INIT};
         STEP_KEEP_INIT: w = '{ACT_KEEP_INIT, BR_NEXT,     COND_NONE,      STEP_IDLE};
         STEP_KEEP:      w = '{ACT_KEEP,      BR_WAIT,     COND_KEEP_DONE, STEP_WALK_INIT};
         STEP_WALK_INIT: w = '{ACT_WALK_INIT, BR_NEXT,     COND_NONE,      STEP_IDLE};
         STEP_WALK:      w = '{ACT_WALK,      BR_WAIT,     COND_WALK_DONE, STEP_ACK};
         STEP_ACK:       w = '{ACT_EMIT_ACK,  BR_WAIT,     COND_OUT_FREE,  STEP_IDLE};
         default:        w = '{ACT_NONE,      BR_GOTO,     COND_NONE,      STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/order_crossover_permutation.sv -----
// Order crossover engine: load, run and read of parent and child permutations.
// A load gives no result; a read registers the child gene and its read-out step moves it
// to the output register once that is free. A run acknowledges after cut reduction, a
// seen-map clearing pass over all MAX_GENES+1 bits, kept-zone copy and parent-two walk at
// one gene a cycle. Throughput: one request at a time; the next is accepted once the
// previous result is in the output register.
// Reset: sequencer idle, num_genes 256, fill pointer zero; gene stores are undefined until written.
// depends on ocx_pkg

module order_crossover_permutation
   import ocx_pkg::*;
#(
   parameter int MAX_GENES = 256
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_position,
   input  logic [8:0] req_gene_first,
   input  logic [8:0] req_gene_second,
   input  logic [7:0] req_cut_start,
   input  logic [7:0] req_cut_end,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [8:0] rsp_child_gene,
   // configuration
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data
);

   localparam int AW = $clog2(MAX_GENES);
   localparam int SW = $clog2(MAX_GENES + 1);
   localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_GENES);

   // wrap-around increment of a position modulo n
   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p, input logic [CW-1:0] n);
      logic [CW-1:0] nx;
      nx = CW'(p) + CW'(1);
      return (nx == n) ? '0 : AW'(nx);
   endfunction

   // gene values above MAX_GENES have no seen bit
   function automatic logic gene_in_map(input logic [8:0] g);
      return CW'(g) <= MAX_C;
   endfunction

   function automatic logic [SW-1:0] seen_index(input logic [8:0] g);
      logic [CW-1:0] gx;
      gx = CW'(g);
      return SW'(gx);
   endfunction

   // memories
   logic [8:0] first_mem  [MAX_GENES];
   logic [8:0] second_mem [MAX_GENES];
   logic [8:0] child_mem  [MAX_GENES];
   logic       seen_mem   [MAX_GENES + 1];

   // registers
   upc_type       upc_ff, upc_in;
   logic [8:0]    csr_num_genes_ff;
   logic [CW-1:0] s_ff, s_in;
   logic [CW-1:0] e_ff, e_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] fp_ff, fp_in;
   logic          keep_go_ff, keep_go_in;
   logic          keep_v_ff, keep_v_in;
   logic [AW-1:0] keep_pos_ff, keep_pos_in;
   logic          walk_v1_ff, walk_v1_in;
   logic          walk_v2_ff, walk_v2_in;
   logic [8:0]    gene2_ff, gene2_in;
   logic          inmap2_ff, inmap2_in;
   logic          pos_ok_ff, pos_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [8:0]    rsp_gene_ff, rsp_gene_in;

   // memory read data
   logic [8:0] first_rd_ff;
   logic [8:0] second_rd_ff;
   logic [8:0] child_rd_ff;
   logic       seen_rd_ff;

   // memory strobes
   logic          parent_we;
   logic          first_re, second_re;
   logic          child_we, child_re;
   logic [AW-1:0] child_waddr, child_raddr;
   logic [8:0]    child_wdata;
   logic          seen_we, seen_re;
   logic [SW-1:0] seen_waddr, seen_raddr;
   logic          seen_wdata;

   ctrl_word_type cw;
   logic [CW-1:0] gene_count;
   logic [CW-1:0] ng_ext;
   logic          req_accept;
   logic          out_free;
   logic          pos_ok;
   logic          cond_true;
   logic          emit;

   // genes in use, clamped to 1..MAX_GENES
   always_comb begin
      ng_ext = CW'(csr_num_genes_ff);
      if (ng_ext == '0) begin
         gene_count = CW'(1);
      end else if (ng_ext > MAX_C) begin
         gene_count = MAX_C;
      end else begin
         gene_count = ng_ext;
      end
   end

   assign cw         = ucode_word(upc_ff);
   assign req_stall  = (upc_ff != STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pos_ok     = CW'(req_position) < MAX_C;

   // branch condition
   always_comb begin
      case (cw.cond)
         COND_OUT_FREE:  cond_true = out_free;
         COND_S_LT_N:    cond_true = s_ff < gene_count;
         COND_E_LT_N:    cond_true = e_ff < gene_count;
         COND_CLR_LAST:  cond_true = cnt_ff == MAX_C;
         COND_KEEP_DONE: cond_true = !keep_go_ff && !keep_v_ff;
         COND_WALK_DONE: cond_true = (cnt_ff == gene_count) && !walk_v1_ff && !walk_v2_ff;
         default:        cond_true = 1'b0;
      endcase
   end

   // step counter next value
   always_comb begin
      case (cw.br)
         BR_NEXT: upc_in = upc_ff + upc_type'(1);
         BR_GOTO: upc_in = cw.target;
         BR_WAIT: upc_in = cond_true ? cw.target : upc_ff;
         BR_DISPATCH: begin
            if (req_accept && req_mode == MODE_RUN) begin
               upc_in = cw.target;
            end else if (req_accept && req_mode == MODE_READ) begin
               upc_in = upc_ff + upc_type'(1);
            end else begin
               upc_in = upc_ff;
            end
         end
         default: upc_in = STEP_IDLE;
      endcase
   end

   // datapath driven by the control word
   always_comb begin
      s_in        = s_ff;
      e_in        = e_ff;
      cnt_in      = cnt_ff;
      ptr_in      = ptr_ff;
      fp_in       = fp_ff;
      keep_go_in  = keep_go_ff;
      keep_v_in   = keep_v_ff;
      keep_pos_in = keep_pos_ff;
      walk_v1_in  = walk_v1_ff;
      walk_v2_in  = walk_v2_ff;
      gene2_in    = gene2_ff;
      inmap2_in   = inmap2_ff;
      pos_ok_in   = pos_ok_ff;
      parent_we   = 1'b0;
      first_re    = 1'b0;
      second_re   = 1'b0;
      child_we    = 1'b0;
      child_re    = 1'b0;
      child_waddr = keep_pos_ff;
      child_raddr = AW'(req_position);
      child_wdata = first_rd_ff;
      seen_we     = 1'b0;
      seen_re     = 1'b0;
      seen_waddr  = SW'(cnt_ff);
      seen_raddr  = seen_index(second_rd_ff);
      seen_wdata  = 1'b0;
      emit        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_gene_in = rsp_gene_ff;
      case (cw.act)
         ACT_IDLE: begin
            if (req_accept) begin
               s_in      = CW'(req_cut_start);
               e_in      = CW'(req_cut_end);
               pos_ok_in = pos_ok;
               parent_we = (req_mode == MODE_LOAD) && pos_ok;
               child_re  = (req_mode == MODE_READ) && pos_ok;
            end
         end
         ACT_EMIT_READ: begin
            emit        = out_free;
            rsp_kind_in = KIND_GENE;
            rsp_gene_in = pos_ok_ff ? child_rd_ff : '0;
         end
         ACT_RED_S: begin
            if (s_ff >= gene_count) begin
               s_in = s_ff - gene_count;
            end
         end
         ACT_RED_E: begin
            if (e_ff >= gene_count) begin
               e_in = e_ff - gene_count;
            end
         end
         ACT_CLR_INIT: begin
            cnt_in = '0;
         end
         ACT_CLR: begin
            seen_we = 1'b1;
            cnt_in  = cnt_ff + CW'(1);
         end
         ACT_KEEP_INIT: begin
            ptr_in     = AW'(s_ff);
            fp_in      = wrap_inc(AW'(e_ff), gene_count);
            keep_go_in = gene_count != CW'(1);
            keep_v_in  = 1'b0;
         end
         ACT_KEEP: begin
            // one parent-one gene fetched and one stored each cycle
            first_re    = keep_go_ff;
            keep_v_in   = keep_go_ff;
            keep_pos_in = ptr_ff;
            if (keep_go_ff) begin
               if (ptr_ff == AW'(e_ff)) begin
                  keep_go_in = 1'b0;
               end else begin
                  ptr_in = wrap_inc(ptr_ff, gene_count);
               end
            end
            if (keep_v_ff) begin
               child_we    = 1'b1;
               child_waddr = keep_pos_ff;
               child_wdata = first_rd_ff;
               seen_we     = gene_in_map(first_rd_ff);
               seen_waddr  = seen_index(first_rd_ff);
               seen_wdata  = 1'b1;
            end
         end
         ACT_WALK_INIT: begin
            ptr_in     = wrap_inc(AW'(e_ff), gene_count);
            cnt_in     = '0;
            walk_v1_in = 1'b0;
            walk_v2_in = 1'b0;
         end
         ACT_WALK: begin
            // stage 0: fetch parent two gene
            if (cnt_ff != gene_count) begin
               second_re  = 1'b1;
               ptr_in     = wrap_inc(ptr_ff, gene_count);
               cnt_in     = cnt_ff + CW'(1);
               walk_v1_in = 1'b1;
            end else begin
               walk_v1_in = 1'b0;
            end
            // stage 1: look up seen bit
            seen_re    = walk_v1_ff && gene_in_map(second_rd_ff);
            walk_v2_in = walk_v1_ff;
            gene2_in   = second_rd_ff;
            inmap2_in  = gene_in_map(second_rd_ff);
            // stage 2: place unseen gene at fill pointer
            if (walk_v2_ff && !(inmap2_ff && seen_rd_ff)) begin
               child_we    = 1'b1;
               child_waddr = fp_ff;
               child_wdata = gene2_ff;
               fp_in       = wrap_inc(fp_ff, gene_count);
            end
         end
         ACT_EMIT_ACK: begin
            emit        = out_free;
            rsp_kind_in = KIND_ACK;
            rsp_gene_in = '0;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff           <= STEP_IDLE;
         csr_num_genes_ff <= 9'd256;
         fp_ff            <= '0;
         keep_go_ff       <= 1'b0;
         keep_v_ff        <= 1'b0;
         walk_v1_ff       <= 1'b0;
         walk_v2_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         fp_ff        <= fp_in;
         keep_go_ff   <= keep_go_in;
         keep_v_ff    <= keep_v_in;
         walk_v1_ff   <= walk_v1_in;
         walk_v2_ff   <= walk_v2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            csr_num_genes_ff <= csr_write_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      e_ff        <= e_in;
      cnt_ff      <= cnt_in;
      ptr_ff      <= ptr_in;
      keep_pos_ff <= keep_pos_in;
      gene2_ff    <= gene2_in;
      inmap2_ff   <= inmap2_in;
      pos_ok_ff   <= pos_ok_in;
      if (emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_gene_ff <= rsp_gene_in;
      end
   end

   // gene stores and seen map
   always_ff @(posedge clock) begin
      if (parent_we) begin
         first_mem[AW'(req_position)]  <= req_gene_first;
         second_mem[AW'(req_position)] <= req_gene_second;
      end
      if (first_re) begin
         first_rd_ff <= first_mem[ptr_ff];
      end
      if (second_re) begin
         second_rd_ff <= second_mem[ptr_ff];
      end
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      if (child_re) begin
         child_rd_ff <= child_mem[child_raddr];
      end
      if (seen_we) begin
         seen_mem[seen_waddr] <= seen_wdata;
      end
      if (seen_re) begin
         seen_rd_ff <= seen_mem[seen_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_child_gene  = rsp_gene_ff;

   // a run request enters the cut reduction next
   a_run_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_RUN) |=> (upc_ff == STEP_RED_S))
      else $error("run request did not start the sequence");

   // cut points are reduced below n before the seen map is cleared
   a_cuts_reduced: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == STEP_CLR_INIT) |-> (s_ff < gene_count && e_ff < gene_count))
      else $error("cut points not reduced modulo n");

   // fill pointer stays inside the permutation during the walk
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == STEP_WALK) |-> (CW'(fp_ff) < gene_count))
      else $error("fill pointer out of range");

   // kept-zone copy traffic only in its own step
   a_keep_confined: assert property (@(posedge clock) disable iff (reset)
      (keep_v_ff || keep_go_ff) |-> (upc_ff == STEP_KEEP))
      else $error("kept-zone copy outside its step");

   // an acknowledgement carries a zero gene
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_ACK) |-> (rsp_child_gene == '0))
      else $error("acknowledgement with nonzero gene");

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for the order crossover engine; a local copy of the parent
// and child tours predicts every acknowledgement and child gene read back
// depends on ocx_pkg and order_crossover_permutation

module tb_top
   import ocx_pkg::*;
();

   localparam int GENE_SLOTS = 256;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT = 5000;
   localparam int HOLD_OFF_SPAN = 300;

   typedef struct packed {
      logic       kind;
      logic [8:0] gene;
   } child_answer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = MODE_LOAD;
   logic [7:0] req_position = 8'd0;
   logic [8:0] req_gene_first = 9'd0;
   logic [8:0] req_gene_second = 9'd0;
   logic [7:0] req_cut_start = 8'd0;
   logic [7:0] req_cut_end = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_result_kind;
   logic [8:0] rsp_child_gene;
   logic       csr_write_enable = 1'b0;
   logic [8:0] csr_write_data = 9'd0;

   // local copy of the engine state
   logic [8:0] num_genes_reg = 9'd256;
   logic [8:0] first_tour [GENE_SLOTS];
   logic [8:0] second_tour [GENE_SLOTS];
   logic [8:0] child_tour [GENE_SLOTS];
   bit         child_written [GENE_SLOTS];

   child_answer_type pending_answers [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_off_cycles = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;

   order_crossover_permutation #(.MAX_GENES(GENE_SLOTS)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_gene_first  (req_gene_first),
      .req_gene_second (req_gene_second),
      .req_cut_start   (req_cut_start),
      .req_cut_end     (req_cut_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_child_gene  (rsp_child_gene),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // append one expected result behind the ones already waiting
   task automatic expect_answer(input child_answer_type answer);
      pending_answers = {pending_answers, answer};
   endtask

   // tour length in use: zero counts as one, large values saturate
   function automatic int tour_length();
      if (num_genes_reg == 9'd0) return 1;
      if (num_genes_reg > GENE_SLOTS) return GENE_SLOTS;
      return int'(num_genes_reg);
   endfunction

   // order crossover over the local tours
   function automatic void apply_crossover(input logic [7:0] cut_lo, input logic [7:0] cut_hi);
      int n, s, e, keep, j, k, i;
      bit seen [GENE_SLOTS+1];
      logic [8:0] g;
      n = tour_length();
      s = int'(cut_lo) % n;
      e = int'(cut_hi) % n;
      keep = (n == 1) ? 0 : ((e + n - s) % n) + 1;
      j = s;
      // kept zone comes straight from parent one
      for (k = 0; k < keep; k++) begin
         g = first_tour[j % n];
         child_tour[j % n] = g;
         child_written[j % n] = 1'b1;
         if (g <= GENE_SLOTS) seen[g] = 1'b1;
         j++;
      end
      // rest in parent-two order after the end cut, genes past the map always unseen
      for (i = 1; i <= n; i++) begin
         g = second_tour[(e + i) % n];
         if (g > GENE_SLOTS || !seen[g]) begin
            child_tour[j % n] = g;
            child_written[j % n] = 1'b1;
            j++;
         end
      end
   endfunction

   // one request through the handshake, then the local state follows it
   task automatic send_request(input logic [1:0] mode, input logic [7:0] position,
                               input logic [8:0] gene_one, input logic [8:0] gene_two,
                               input logic [7:0] cut_lo, input logic [7:0] cut_hi);
      child_answer_type answer;
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_position    <= position;
      req_gene_first  <= gene_one;
      req_gene_second <= gene_two;
      req_cut_start   <= cut_lo;
      req_cut_end     <= cut_hi;
      do @(posedge clock); while (req_stall !== 1'b0);
      // position is 8 bits, so every load and read lands inside the store
      case (mode)
         MODE_LOAD: begin
            first_tour[position] = gene_one;
            second_tour[position] = gene_two;
         end
         MODE_RUN: begin
            apply_crossover(cut_lo, cut_hi);
            answer.kind = KIND_ACK;
            answer.gene = 9'd0;
            expect_answer(answer);
         end
         MODE_READ: begin
            answer.kind = KIND_GENE;
            answer.gene = child_tour[position];
            expect_answer(answer);
         end
         default: ;
      endcase
   endtask

   task automatic load_genes(input logic [7:0] position, input logic [8:0] gene_one,
                             input logic [8:0] gene_two);
      send_request(MODE_LOAD, position, gene_one, gene_two, 8'($urandom), 8'($urandom));
   endtask

   task automatic start_crossover(input logic [7:0] cut_lo, input logic [7:0] cut_hi);
      send_request(MODE_RUN, 8'($urandom), 9'($urandom), 9'($urandom), cut_lo, cut_hi);
   endtask

   task automatic read_child(input logic [7:0] position);
      send_request(MODE_READ, position, 9'($urandom), 9'($urandom), 8'($urandom),
                   8'($urandom));
   endtask

   // let everything in flight finish, loads included
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gene_count(input logic [8:0] value);
      wait_until_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      num_genes_reg = value;
   endtask

   // a child position that some run has written, mostly inside the tour in use
   function automatic logic [7:0] pick_child_position();
      int start, k, p;
      if ($urandom_range(0, 1) == 0) start = $urandom_range(0, tour_length() - 1);
      else start = $urandom_range(0, GENE_SLOTS - 1);
      for (k = 0; k < GENE_SLOTS; k++) begin
         p = (start + k) % GENE_SLOTS;
         if (child_written[p]) return 8'(p);
      end
      return 8'(start);
   endfunction

   // set the tour length, optionally load fresh shuffled parents, then run and read back
   task automatic run_tour_phase(input logic [8:0] setting, input int rounds, input int reads,
                                 input bit fresh);
      int n, r, q, i, t;
      logic [8:0] order_one [GENE_SLOTS];
      logic [8:0] order_two [GENE_SLOTS];
      logic [8:0] swap;
      write_gene_count(setting);
      n = tour_length();
      if (fresh) begin
         for (i = 0; i < n; i++) begin
            order_one[i] = 9'(i);
            order_two[i] = 9'(i);
         end
         for (i = n - 1; i > 0; i--) begin
            t = $urandom_range(0, i);
            swap = order_one[i];
            order_one[i] = order_one[t];
            order_one[t] = swap;
            t = $urandom_range(0, i);
            swap = order_two[i];
            order_two[i] = order_two[t];
            order_two[t] = swap;
         end
         // a few stray genes break the permutations
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) order_one[i] = 9'($urandom);
            if ($urandom_range(0, 11) == 0) order_two[i] = 9'($urandom);
            load_genes(8'(i), order_one[i], order_two[i]);
         end
      end
      for (r = 0; r < rounds; r++) begin
         if ($urandom_range(0, 3) == 0) load_genes(8'($urandom), 9'($urandom), 9'($urandom));
         if ($urandom_range(0, 7) == 0)
            send_request(MODE_UNUSED, 8'($urandom), 9'($urandom), 9'($urandom),
                         8'($urandom), 8'($urandom));
         if ($urandom_range(0, 1) == 0) start_crossover(8'($urandom), 8'($urandom));
         else start_crossover(8'($urandom_range(0, n - 1)), 8'($urandom_range(0, n - 1)));
         for (q = 0; q < reads; q++) read_child(pick_child_position());
      end
   endtask

   // four-gene tours with gene extremes, wrapped and equal cuts, unused mode
   task automatic test_basic_crossover();
      int p;
      write_gene_count(9'd4);
      load_genes(8'd0, 9'd0, 9'd511);
      load_genes(8'd1, 9'd256, 9'd256);
      load_genes(8'd2, 9'd511, 9'd0);
      load_genes(8'd3, 9'd3, 9'd3);
      load_genes(8'd255, 9'd511, 9'd511);
      send_request(MODE_UNUSED, 8'd255, 9'd511, 9'd511, 8'd255, 8'd255);
      start_crossover(8'd1, 8'd2);
      for (p = 0; p < 4; p++) read_child(8'(p));
      // both cuts past the tour end reduce to the same gene
      start_crossover(8'd255, 8'd255);
      for (p = 0; p < 4; p++) read_child(8'(p));
      // kept zone wraps around the tour end
      start_crossover(8'd3, 8'd0);
      read_child(8'd0);
      read_child(8'd3);
   endtask

   // zero gene count means one gene: empty kept zone, parent two fills the child
   task automatic test_single_gene();
      write_gene_count(9'd0);
      start_crossover(8'd200, 8'd77);
      read_child(8'd0);
   endtask

   task automatic test_small_tours();
      run_tour_phase(9'd2, 6, 2, 1'b1);
      run_tour_phase(9'd5, 8, 3, 1'b1);
      run_tour_phase(9'd16, 8, 4, 1'b1);
   endtask

   // receiver holds off long enough that the engine backs up into the request side
   task automatic test_result_holdoff();
      int q;
      sender_idles = 1'b0;
      hold_off_cycles = HOLD_OFF_SPAN;
      for (q = 0; q < 6; q++) read_child(pick_child_position());
      start_crossover(8'($urandom), 8'($urandom));
      for (q = 0; q < 6; q++) read_child(pick_child_position());
      sender_idles = 1'b1;
   endtask

   // oversized count saturates to the full store, then the full count on the same parents
   task automatic test_full_tour();
      run_tour_phase(9'd511, 4, 6, 1'b1);
      if (child_written[255]) read_child(8'd255);
      run_tour_phase(9'd256, 4, 6, 1'b0);
   endtask

   task automatic test_random_tours();
      int k;
      for (k = 0; k < 3; k++) run_tour_phase(9'($urandom_range(3, 40)), 6, 3, 1'b1);
   endtask

   // closing stretch with both sides running flat out
   task automatic test_steady_stream();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      run_tour_phase(9'd1, 4, 1, 1'b1);
      run_tour_phase(9'($urandom_range(2, 12)), 5, 3, 1'b1);
   endtask

   // receiver side: random stall bursts and the requested long hold-off
   initial begin : receiver_side
      int span;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            span = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin : answer_check
      child_answer_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0b gene %0d",
                                      rsp_result_kind, rsp_child_gene));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_result_kind !== want.kind)
               report_mismatch($sformatf("result_kind %0b, expected %0b",
                                         rsp_result_kind, want.kind));
            if (rsp_child_gene !== want.gene)
               report_mismatch($sformatf("child_gene %0d, expected %0d",
                                         rsp_child_gene, want.gene));
         end
      end
   end

   initial begin : stimulus
      int k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_crossover();
      test_single_gene();
      test_small_tours();
      test_result_holdoff();
      test_full_tour();
      test_random_tours();
      test_steady_stream();
      // drain outstanding results, then watch for strays
      req_valid <= 1'b0;
      for (k = 0; k < DRAIN_LIMIT && pending_answers.size() != 0; k++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
      if (mismatch_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ocx_pkg.sv
rtl/order_crossover_permutation.sv
verif/tb_top.sv
